// ===== hw/rtl/midpoint_circle_points_defines.svh =====
// Assertion helpers for the circle point generator.
`ifndef MIDPOINT_CIRCLE_POINTS_DEFINES_SVH
`define MIDPOINT_CIRCLE_POINTS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MCP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled in reset
`define MCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/mcp_pkg.sv =====
package mcp_pkg;

   localparam int SCREEN_WIDTH  = 240;
   localparam int SCREEN_HEIGHT = 320;

   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   localparam logic [2:0] LAST_POINT = 3'd7;

   typedef struct packed {
      logic [10:0]        x;
      logic [10:0]        y;
      logic signed [11:0] col;
      logic signed [11:0] row;
      logic [15:0]        color;
      logic [2:0]         idx;
      logic               done;
   } point_src_type;

   typedef struct packed {
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
      logic [15:0] color;
      logic        visible;
      logic        last;
      logic        done;
   } point_type;

endpackage

// ===== hw/rtl/midpoint_circle_points.sv =====
// Midpoint circle outline point generator.
// A start beat gives no result, nor does a step beat while no circle is active.
// An active step beat gives eight point beats through the work and response registers,
// one per cycle while the receiver is ready; the point sequencer holds one step.
// Synchronous active-high reset clears the active flag and the sequencer and output valid flags.
`include "midpoint_circle_points_defines.svh"

module midpoint_circle_points (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic signed [11:0] req_center_x,
   input  logic signed [11:0] req_center_y,
   input  logic [9:0]         req_radius,
   input  logic [15:0]        req_pen_color,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [10:0]        rsp_pixel_x,
   output logic [10:0]        rsp_pixel_y,
   output logic [15:0]        rsp_point_color,
   output logic               rsp_visible,
   output logic               rsp_last_of_step,
   output logic               rsp_circle_done
);

   logic [10:0]        offset_x_ff, offset_x_in;
   logic [10:0]        offset_y_ff, offset_y_in;
   logic signed [13:0] decision_ff, decision_in;
   logic signed [11:0] centre_col_ff;
   logic signed [11:0] centre_row_ff;
   logic [15:0]        outline_color_ff;
   logic               active_ff, active_in;

   logic                   work_valid_ff, work_valid_in;
   mcp_pkg::point_src_type work_ff, work_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mcp_pkg::point_type     rsp_ff;
   mcp_pkg::point_type     point;

   logic               req_fire;
   logic               load_rsp;
   logic               start_fire;
   logic               step_fire;
   logic signed [13:0] x_ext;
   logic signed [13:0] y_ext;
   logic [11:0]        nx12;
   logic signed [11:0] ny12;
   logic               step_done;

   mcp_point u_point (
      .src (work_ff),
      .pnt (point)
   );

   assign load_rsp   = work_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !work_valid_ff || (load_rsp && work_ff.idx == mcp_pkg::LAST_POINT);
   assign req_fire   = req_valid && req_ready;
   assign start_fire = req_fire && (req_operation == mcp_pkg::OP_START);
   assign step_fire  = req_fire && (req_operation == mcp_pkg::OP_STEP) && active_ff;

   always_comb begin
      x_ext       = {3'b000, offset_x_ff};
      y_ext       = {{3{offset_y_ff[10]}}, offset_y_ff};
      nx12        = {1'b0, offset_x_ff} + 12'd1;
      offset_x_in = offset_x_ff;
      offset_y_in = offset_y_ff;
      decision_in = decision_ff;
      active_in   = active_ff;
      if (decision_ff[13]) begin
         ny12 = {offset_y_ff[10], offset_y_ff};
      end else begin
         ny12 = {offset_y_ff[10], offset_y_ff} - 12'sd1;
      end
      step_done = signed'(nx12) > ny12;

      if (start_fire) begin
         offset_x_in = 11'd0;
         offset_y_in = {1'b0, req_radius};
         decision_in = 14'sd3 - signed'({3'b000, req_radius, 1'b0});
         active_in   = 1'b1;
      end else if (step_fire) begin
         if (decision_ff[13]) begin
            decision_in = decision_ff + (x_ext <<< 2) + 14'sd6;
         end else begin
            decision_in = decision_ff + ((x_ext - y_ext) <<< 2) + 14'sd10;
         end
         offset_x_in = nx12[10:0];
         offset_y_in = ny12[10:0];
         active_in   = !step_done;
      end
   end

   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      if (load_rsp) begin
         work_in.idx = work_ff.idx + 3'd1;
         if (work_ff.idx == mcp_pkg::LAST_POINT) begin
            work_valid_in = 1'b0;
         end
      end
      if (step_fire) begin
         work_valid_in = 1'b1;
         work_in.x     = offset_x_ff;
         work_in.y     = offset_y_ff;
         work_in.col   = centre_col_ff;
         work_in.row   = centre_row_ff;
         work_in.color = outline_color_ff;
         work_in.idx   = 3'd0;
         work_in.done  = step_done;
      end
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         active_ff     <= active_in;
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_x_ff <= offset_x_in;
      offset_y_ff <= offset_y_in;
      decision_ff <= decision_in;
      work_ff     <= work_in;
      if (start_fire) begin
         centre_col_ff    <= req_center_x;
         centre_row_ff    <= req_center_y;
         outline_color_ff <= req_pen_color;
      end
      if (load_rsp) begin
         rsp_ff <= point;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = rsp_ff.pixel_x;
   assign rsp_pixel_y      = rsp_ff.pixel_y;
   assign rsp_point_color  = rsp_ff.color;
   assign rsp_visible      = rsp_ff.visible;
   assign rsp_last_of_step = rsp_ff.last;
   assign rsp_circle_done  = rsp_ff.done;

   `MCP_ASSERT_NOW(a_done_on_last, clock, reset, rsp_valid_ff && rsp_ff.done, rsp_ff.last)
   `MCP_ASSERT_NOW(a_hidden_zero, clock, reset, rsp_valid_ff && !rsp_ff.visible,
      rsp_ff.pixel_x == 11'd0 && rsp_ff.pixel_y == 11'd0)
   `MCP_ASSERT_NOW(a_busy_blocks, clock, reset,
      work_valid_ff && work_ff.idx != mcp_pkg::LAST_POINT, !req_ready)
   `MCP_ASSERT_NEXT(a_done_idles, clock, reset, step_fire && step_done, !active_ff)

endmodule

// ===== hw/rtl/mcp_point.sv =====
module mcp_point (
   input  mcp_pkg::point_src_type src,
   output mcp_pkg::point_type     pnt
);

   logic signed [12:0] a_off;
   logic signed [12:0] b_off;
   logic signed [12:0] dx;
   logic signed [12:0] dy;
   logic signed [12:0] col;
   logic signed [12:0] row;
   logic               vis;

   always_comb begin
      a_off = {2'b00, src.x};
      b_off = {{2{src.y[10]}}, src.y};
      dx    = src.idx[2] ? b_off : a_off;
      dy    = src.idx[2] ? a_off : b_off;
      if (src.idx[0]) begin
         dx = -dx;
      end
      if (src.idx[1]) begin
         dy = -dy;
      end
      col = {src.col[11], src.col} + dx;
      row = {src.row[11], src.row} + dy;
      vis = !col[12] && (col[11:0] < 12'(mcp_pkg::SCREEN_WIDTH))
         && !row[12] && (row[11:0] < 12'(mcp_pkg::SCREEN_HEIGHT));

      pnt.pixel_x = vis ? col[10:0] : 11'd0;
      pnt.pixel_y = vis ? row[10:0] : 11'd0;
      pnt.color   = src.color;
      pnt.visible = vis;
      pnt.last    = (src.idx == mcp_pkg::LAST_POINT);
      pnt.done    = (src.idx == mcp_pkg::LAST_POINT) && src.done;
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

   typedef enum logic [1:0] {
      RX_FLOW,
      RX_LIGHT,
      RX_HEAVY,
      RX_PATTERN
   } rx_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_operation = mcp_pkg::OP_STEP;
   logic signed [11:0] req_center_x = '0;
   logic signed [11:0] req_center_y = '0;
   logic [9:0]         req_radius = '0;
   logic [15:0]        req_pen_color = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [10:0]        rsp_pixel_x;
   logic [10:0]        rsp_pixel_y;
   logic [15:0]        rsp_point_color;
   logic               rsp_visible;
   logic               rsp_last_of_step;
   logic               rsp_circle_done;

   // circle tracker state
   logic [10:0]        track_x = '0;
   logic signed [10:0] track_y = '0;
   logic signed [13:0] track_d = '0;
   logic signed [11:0] pen_col = '0;
   logic signed [11:0] pen_row = '0;
   logic [15:0]        pen_rgb = '0;
   logic               tracing = 1'b0;

   mcp_pkg::point_type expected_points[$];
   mcp_pkg::point_type want;
   int                 mismatch_count = 0;
   int                 drawing_beats = 0;
   int                 burst_left = 0;
   rx_mode_type        rx_mode = RX_FLOW;
   int                 rx_timer = 0;
   logic [7:0]         rx_pattern = 8'h5b;

   midpoint_circle_points i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .req_pen_color    (req_pen_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_point_color  (rsp_point_color),
      .rsp_visible      (rsp_visible),
      .rsp_last_of_step (rsp_last_of_step),
      .rsp_circle_done  (rsp_circle_done)
   );

   always #2 clock = ~clock;

   // update the tracker for one accepted beat and queue the points it yields
   task automatic trace_beat(input logic op, input logic signed [11:0] cx,
                             input logic signed [11:0] cy, input logic [9:0] r,
                             input logic [15:0] rgb);
      int                 x, y, nx, ny, nd, dx, dy, col, row;
      logic               done;
      mcp_pkg::point_type pt;
      if (op == mcp_pkg::OP_START) begin
         pen_col = cx;
         pen_row = cy;
         pen_rgb = rgb;
         track_x = '0;
         track_y = {1'b0, r};
         nd = 3 - 2 * int'(r);
         track_d = nd[13:0];
         tracing = 1'b1;
         drawing_beats++;
      end else if (tracing) begin
         x = int'(track_x);
         y = int'(track_y);
         if (track_d < 0) begin
            nd = int'(track_d) + 4 * x + 6;
            ny = y;
         end else begin
            nd = int'(track_d) + 4 * (x - y) + 10;
            ny = y - 1;
         end
         nx = x + 1;
         done = nx > ny;
         for (int k = 0; k < 8; k++) begin
            dx = (k < 4) ? x : y;
            dy = (k < 4) ? y : x;
            if (k % 2) dx = -dx;
            if ((k / 2) % 2) dy = -dy;
            col = int'(pen_col) + dx;
            row = int'(pen_row) + dy;
            pt.visible = col >= 0 && col < mcp_pkg::SCREEN_WIDTH && row >= 0
               && row < mcp_pkg::SCREEN_HEIGHT;
            pt.pixel_x = pt.visible ? col[10:0] : '0;
            pt.pixel_y = pt.visible ? row[10:0] : '0;
            pt.color   = pen_rgb;
            pt.last    = (k == 7);
            pt.done    = (k == 7) && done;
            expected_points.push_back(pt);
         end
         track_d = nd[13:0];
         track_x = nx[10:0];
         track_y = ny[10:0];
         if (done) tracing = 1'b0;
         drawing_beats++;
      end
   endtask

   task automatic send_item(input logic op, input logic signed [11:0] cx,
                            input logic signed [11:0] cy, input logic [9:0] r,
                            input logic [15:0] rgb);
      int idle_gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         idle_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (idle_gap > 0) begin
            req_valid <= 1'b0;
            repeat (idle_gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_center_x  <= cx;
      req_center_y  <= cy;
      req_radius    <= r;
      req_pen_color <= rgb;
      do @(posedge clock); while (!req_ready);
      trace_beat(op, cx, cy, r, rgb);
   endtask

   task automatic send_step();
      send_item(mcp_pkg::OP_STEP, 12'($urandom), 12'($urandom), 10'($urandom),
                16'($urandom));
   endtask

   // start a circle and advance it until done or until the step budget runs out
   task automatic run_circle(input logic signed [11:0] cx, input logic signed [11:0] cy,
                             input logic [9:0] r, input logic [15:0] rgb, input int max_steps);
      int n;
      n = 0;
      send_item(mcp_pkg::OP_START, cx, cy, r, rgb);
      while (tracing && n < max_steps) begin
         send_step();
         n++;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0);
   endtask

   task automatic test_idle_steps();
      send_item(mcp_pkg::OP_STEP, 12'h7ff, 12'h800, 10'h3ff, 16'hffff);
      send_item(mcp_pkg::OP_STEP, 12'h000, 12'hfff, 10'h000, 16'h0000);
   endtask

   task automatic test_zero_radius();
      run_circle(12'sd0, 12'sd0, 10'd0, 16'h1234, 4);
      send_step();
   endtask

   task automatic test_extreme_centers();
      run_circle(12'sh800, 12'sh800, 10'd1023, 16'hffff, 3);
      run_circle(12'sd2047, 12'sd2047, 10'd1023, 16'h0000, 2);
      run_circle(12'sd120, 12'sd160, 10'd1023, 16'hf800, 2);
   endtask

   task automatic test_screen_edges();
      run_circle(12'(mcp_pkg::SCREEN_WIDTH - 1), 12'(mcp_pkg::SCREEN_HEIGHT - 1), 10'd1,
                 16'h07e0, 8);
      run_circle(12'(mcp_pkg::SCREEN_WIDTH), 12'(mcp_pkg::SCREEN_HEIGHT), 10'd0, 16'h001f, 8);
      run_circle(-12'sd1, -12'sd1, 10'd0, 16'haaaa, 8);
      run_circle(12'sd1, 12'sd2, 10'd2, 16'h5555, 8);
      run_circle(12'sd120, 12'sd160, 10'd5, 16'ha5a5, 8);
   endtask

   task automatic test_random_circles();
      logic signed [11:0] cx, cy;
      logic [9:0]         r;
      int                 limit, first;
      first = drawing_beats;
      while (drawing_beats - first < 150) begin
         if ($urandom_range(0, 9) < 8) begin
            cx = 12'($urandom);
            cy = 12'($urandom);
            if ($urandom_range(0, 3) != 0)
               cx = 12'($urandom_range(0, mcp_pkg::SCREEN_WIDTH - 1));
            if ($urandom_range(0, 3) != 0)
               cy = 12'($urandom_range(0, mcp_pkg::SCREEN_HEIGHT - 1));
            r = 10'($urandom_range(0, 40));
            if ($urandom_range(0, 7) == 0) r = 10'($urandom);
            limit = 1024;
            if (r > 40 || $urandom_range(0, 5) == 0) limit = $urandom_range(1, 10);
            run_circle(cx, cy, r, 16'($urandom), limit);
         end else begin
            repeat ($urandom_range(1, 4))
               send_item(1'($urandom_range(0, 1)), 12'($urandom), 12'($urandom),
                         10'($urandom), 16'($urandom));
         end
      end
   endtask

   function automatic void check_field(input string what, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, exp_val, act_val);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $display("%0t unexpected point: expected none, actual x=%0d y=%0d", $time,
                     rsp_pixel_x, rsp_pixel_y);
            mismatch_count++;
         end else begin
            want = expected_points.pop_front();
            check_field("pixel_x", int'(want.pixel_x), int'(rsp_pixel_x));
            check_field("pixel_y", int'(want.pixel_y), int'(rsp_pixel_y));
            check_field("point_color", int'(want.color), int'(rsp_point_color));
            check_field("visible", int'(want.visible), int'(rsp_visible));
            check_field("last_of_step", int'(want.last), int'(rsp_last_of_step));
            check_field("circle_done", int'(want.done), int'(rsp_circle_done));
         end
      end
   end

   // receiver stalls, switching style each time its random timer runs out
   always @(posedge clock) begin
      if (rx_timer == 0) begin
         rx_mode    <= rx_mode_type'($urandom_range(0, 3));
         rx_timer   <= $urandom_range(16, 80);
         rx_pattern <= 8'($urandom) | 8'h01;
      end else begin
         rx_timer   <= rx_timer - 1;
         rx_pattern <= {rx_pattern[0], rx_pattern[7:1]};
      end
      case (rx_mode)
         RX_FLOW: rsp_ready <= 1'b1;
         RX_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= rx_pattern[0];
      endcase
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_steps();
      test_zero_radius();
      test_extreme_centers();
      test_screen_edges();
      test_random_circles();
      drain();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mcp_pkg.sv
hw/rtl/mcp_point.sv
hw/rtl/midpoint_circle_points.sv
bench/testbench.sv
